@@ rtl/compressor_feedback_delay_chain_defines.svh @@
// assertion macros for the compressor and echo checker
// needs clk and rst_n in the scope of each use
`ifndef COMPRESSOR_FEEDBACK_DELAY_CHAIN_DEFINES_SVH
`define COMPRESSOR_FEEDBACK_DELAY_CHAIN_DEFINES_SVH

// consequent checked in the cycle after the antecedent
`define CFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfd check failed");

// consequent checked in the same cycle
`define CFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfd check failed");

`endif

@@ rtl/cfd_pkg.sv @@
// shared types, constants and tables for the compressor and echo block
// no dependencies
package cfd_pkg;

  localparam int MAX_DELAY_DEF   = 65536;
  localparam int CHANNELS_DEF    = 2;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int DB_PER_OCTAVE_Q8  = 1541;
  localparam int OCTAVE_PER_DB_Q16 = 10885;
  localparam int ONE_Q16           = 65536;
  localparam logic [15:0] FEEDBACK_RST = 16'd19661;

  localparam int APB_AW = 5;

  typedef enum logic [2:0] {
    REG_FX_ENABLE      = 3'd0,
    REG_COMP_THRESHOLD = 3'd1,
    REG_COMP_SLOPE     = 3'd2,
    REG_DELAY_LENGTH   = 3'd3,
    REG_DELAY_MIX      = 3'd4,
    REG_DELAY_FEEDBACK = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic              fx_enable;
    logic signed [6:0] comp_threshold_db;
    logic [15:0]       comp_slope;
    logic [15:0]       delay_length;
    logic [16:0]       delay_mix;
    logic [15:0]       delay_feedback;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEVEL,
    ST_ATT,
    ST_EXPO,
    ST_GAIN,
    ST_SCALE,
    ST_READ,
    ST_FBK,
    ST_WRITE,
    ST_WET,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ATT,
    MUL_EXP,
    MUL_SCALE,
    MUL_FBK,
    MUL_DRY,
    MUL_WET
  } mul_op_t;

  typedef struct packed {
    logic    load_in;
    logic    load_level;
    mul_op_t mul_op;
    logic    load_gain;
    logic    mem_rd;
    logic    mem_wr;
    logic    load_out;
    logic    clr_step;
  } cmd_t;

  typedef struct packed {
    logic fx_on;
    logic comp_on;
    logic echo_on;
    logic out_free;
    logic clr_last;
  } sts_t;

  // 20*log10 of the mantissa 1 + f/32, Q8.8
  localparam logic [10:0] LOGT [32] = '{
    11'd0,    11'd68,   11'd135,  11'd199,  11'd262,  11'd323,  11'd382,  11'd440,
    11'd496,  11'd551,  11'd605,  11'd657,  11'd708,  11'd758,  11'd807,  11'd855,
    11'd902,  11'd947,  11'd992,  11'd1036, 11'd1080, 11'd1122, 11'd1163, 11'd1204,
    11'd1244, 11'd1284, 11'd1322, 11'd1360, 11'd1398, 11'd1435, 11'd1471, 11'd1506
  };

  // 2^(-j/32) in Q1.16
  localparam logic [16:0] EXPT [32] = '{
    17'd65536, 17'd64132, 17'd62757, 17'd61413, 17'd60097, 17'd58809, 17'd57549,
    17'd56316, 17'd55109, 17'd53928, 17'd52773, 17'd51642, 17'd50535, 17'd49452,
    17'd48392, 17'd47355, 17'd46341, 17'd45348, 17'd44377, 17'd43427, 17'd42495,
    17'd41583, 17'd40690, 17'd39817, 17'd38968, 17'd38132, 17'd37316, 17'd36517,
    17'd35734, 17'd34968, 17'd34219, 17'd33486
  };

endpackage

@@ rtl/cfd_if.sv @@
// stream interfaces for input samples and processed samples
// width follows SAMPLE_BITS; no other dependencies
interface cfd_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          channel;
  modport source (output valid, sample_in, channel, input ready);
  modport sink (input valid, sample_in, channel, output ready);
endinterface

interface cfd_out_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          channel_out;
  modport source (output valid, sample_out, channel_out, input ready);
  modport sink (input valid, sample_out, channel_out, output ready);
endinterface

@@ rtl/cfd_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module cfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ rtl/cfd_regs.sv @@
// apb configuration registers
// depends on cfd_pkg
module cfd_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cfd_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output cfd_pkg::cfg_t              cfg
);
  cfd_pkg::cfg_t cfg_r, cfg_nxt;
  logic [2:0]    idx;
  logic          wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        cfd_pkg::REG_FX_ENABLE:      cfg_nxt.fx_enable = pwdata[0];
        cfd_pkg::REG_COMP_THRESHOLD: cfg_nxt.comp_threshold_db = pwdata[6:0];
        cfd_pkg::REG_COMP_SLOPE:     cfg_nxt.comp_slope = pwdata[15:0];
        cfd_pkg::REG_DELAY_LENGTH:   cfg_nxt.delay_length = pwdata[15:0];
        cfd_pkg::REG_DELAY_MIX:      cfg_nxt.delay_mix = pwdata[16:0];
        cfd_pkg::REG_DELAY_FEEDBACK: cfg_nxt.delay_feedback = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      cfd_pkg::REG_FX_ENABLE:      prdata = {31'd0, cfg_r.fx_enable};
      cfd_pkg::REG_COMP_THRESHOLD: prdata = {25'd0, cfg_r.comp_threshold_db};
      cfd_pkg::REG_COMP_SLOPE:     prdata = {16'd0, cfg_r.comp_slope};
      cfd_pkg::REG_DELAY_LENGTH:   prdata = {16'd0, cfg_r.delay_length};
      cfd_pkg::REG_DELAY_MIX:      prdata = {15'd0, cfg_r.delay_mix};
      cfd_pkg::REG_DELAY_FEEDBACK: prdata = {16'd0, cfg_r.delay_feedback};
      default:                     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{fx_enable: 1'b0, comp_threshold_db: 7'sd0, comp_slope: 16'd0,
                 delay_length: 16'd0, delay_mix: 17'd0,
                 delay_feedback: cfd_pkg::FEEDBACK_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end
endmodule

@@ rtl/cfd_ctrl.sv @@
// sequencing state machine for the compressor and echo datapath
// depends on cfd_pkg
module cfd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cfd_pkg::sts_t sts,
  output cfd_pkg::cmd_t cmd
);
  cfd_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cfd_pkg::ST_CLEAR: if (sts.clr_last) state_nxt = cfd_pkg::ST_IDLE;
      cfd_pkg::ST_IDLE:  if (in_valid) state_nxt = cfd_pkg::ST_LEVEL;
      cfd_pkg::ST_LEVEL: begin
        priority if (!sts.fx_on)  state_nxt = cfd_pkg::ST_OUT;
        else if (sts.comp_on)     state_nxt = cfd_pkg::ST_ATT;
        else if (sts.echo_on)     state_nxt = cfd_pkg::ST_READ;
        else                      state_nxt = cfd_pkg::ST_OUT;
      end
      cfd_pkg::ST_ATT:   state_nxt = cfd_pkg::ST_EXPO;
      cfd_pkg::ST_EXPO:  state_nxt = cfd_pkg::ST_GAIN;
      cfd_pkg::ST_GAIN:  state_nxt = cfd_pkg::ST_SCALE;
      cfd_pkg::ST_SCALE: state_nxt = sts.echo_on ? cfd_pkg::ST_READ : cfd_pkg::ST_OUT;
      cfd_pkg::ST_READ:  state_nxt = cfd_pkg::ST_FBK;
      cfd_pkg::ST_FBK:   state_nxt = cfd_pkg::ST_WRITE;
      cfd_pkg::ST_WRITE: state_nxt = cfd_pkg::ST_WET;
      cfd_pkg::ST_WET:   state_nxt = cfd_pkg::ST_OUT;
      cfd_pkg::ST_OUT:   if (sts.out_free) state_nxt = cfd_pkg::ST_IDLE;
      default:           state_nxt = cfd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.mul_op = cfd_pkg::MUL_NONE;
    in_ready = 1'b0;
    unique case (state_r)
      cfd_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
      cfd_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      cfd_pkg::ST_LEVEL: cmd.load_level = 1'b1;
      cfd_pkg::ST_ATT:   cmd.mul_op = cfd_pkg::MUL_ATT;
      cfd_pkg::ST_EXPO:  cmd.mul_op = cfd_pkg::MUL_EXP;
      cfd_pkg::ST_GAIN:  cmd.load_gain = 1'b1;
      cfd_pkg::ST_SCALE: cmd.mul_op = cfd_pkg::MUL_SCALE;
      cfd_pkg::ST_READ:  cmd.mem_rd = 1'b1;
      cfd_pkg::ST_FBK:   cmd.mul_op = cfd_pkg::MUL_FBK;
      cfd_pkg::ST_WRITE: begin
        cmd.mem_wr = 1'b1;
        cmd.mul_op = cfd_pkg::MUL_DRY;
      end
      cfd_pkg::ST_WET:   cmd.mul_op = cfd_pkg::MUL_WET;
      cfd_pkg::ST_OUT:   cmd.load_out = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfd_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

@@ rtl/cfd_dp.sv @@
// datapath: level detector, shared q0.16 multiplier, echo addressing, output register
// depends on cfd_pkg; drives the echo ram ports
module cfd_dp #(
  parameter int MAX_DELAY   = cfd_pkg::MAX_DELAY_DEF,
  parameter int CHANNELS    = cfd_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = cfd_pkg::SAMPLE_BITS_DEF,
  localparam int DEPTH = CHANNELS * MAX_DELAY,
  localparam int DAW   = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfd_pkg::cfg_t                 cfg,
  input  cfd_pkg::cmd_t                 cmd,
  output cfd_pkg::sts_t                 sts,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          channel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          channel_out,
  output logic                          ram_we,
  output logic [DAW-1:0]                ram_waddr,
  output logic [SAMPLE_BITS-1:0]        ram_wdata,
  output logic                          ram_re,
  output logic [DAW-1:0]                ram_raddr,
  input  logic [SAMPLE_BITS-1:0]        ram_rdata
);
  localparam int SB      = SAMPLE_BITS;
  localparam int VW      = (SB + 1 > 17) ? SB + 1 : 17;
  localparam int AW      = $clog2(MAX_DELAY);
  localparam int CW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PBW     = $clog2(SB);
  localparam int LW      = (AW + 1 > 16) ? AW + 1 : 16;
  localparam int FLOOR_M = (2 ** (SB - 1)) / 10000;

  logic signed [SB-1:0] x_r, d_r, z_r;
  logic                 ch_r;
  logic [SB-1:0]        m_r;
  logic [15:0]          over_r;
  logic signed [VW-1:0] prod_r;
  logic [16:0]          gain_r;
  logic [AW-1:0]        wi_r [CHANNELS];
  logic [DAW-1:0]       clr_cnt_r;
  logic                 out_valid_r;
  logic signed [SB-1:0] out_sample_r;
  logic                 out_ch_r;

  // level detector
  logic [PBW-1:0]       p;
  logic [SB-1:0]        norm;
  logic [4:0]           frac;
  logic signed [19:0]   lvl, over;

  always_comb begin
    p = '0;
    for (int i = 0; i < SB; i++) begin
      if (m_r[i]) p = PBW'(i);
    end
    norm = m_r << (PBW'(SB - 1) - p);
    frac = norm[SB-2 -: 5];
    if (m_r <= SB'(FLOOR_M)) begin
      lvl = -20'sd20480;
    end else begin
      lvl = 20'(($signed({1'b0, p}) - (SB - 1)) * cfd_pkg::DB_PER_OCTAVE_Q8)
          + $signed({9'd0, cfd_pkg::LOGT[frac]});
    end
    over = lvl - (20'(cfg.comp_threshold_db) <<< 8);
  end

  // shared sign-magnitude q0.16 multiplier
  logic signed [VW-1:0] mul_v;
  logic [16:0]          mul_c;
  logic [16:0]          mix_c;
  logic [VW-1:0]        mul_mag;
  logic [VW+16:0]       mul_full;
  logic [VW-1:0]        mul_sh;
  logic signed [VW-1:0] mul_res;

  assign mix_c = (cfg.delay_mix > 17'd65536) ? 17'd65536 : cfg.delay_mix;

  always_comb begin
    mul_v = '0;
    mul_c = '0;
    unique case (cmd.mul_op)
      cfd_pkg::MUL_ATT:   begin mul_v = VW'({1'b0, over_r}); mul_c = {1'b0, cfg.comp_slope}; end
      cfd_pkg::MUL_EXP:   begin mul_v = prod_r; mul_c = 17'(cfd_pkg::OCTAVE_PER_DB_Q16); end
      cfd_pkg::MUL_SCALE: begin mul_v = VW'(x_r); mul_c = gain_r; end
      cfd_pkg::MUL_FBK:   begin mul_v = VW'($signed(ram_rdata)); mul_c = {1'b0, cfg.delay_feedback}; end
      cfd_pkg::MUL_DRY:   begin mul_v = VW'(d_r); mul_c = 17'(cfd_pkg::ONE_Q16) - mix_c; end
      cfd_pkg::MUL_WET:   begin mul_v = VW'(z_r); mul_c = mix_c; end
      default: ;
    endcase
    mul_mag  = mul_v[VW-1] ? VW'(-mul_v) : VW'(mul_v);
    mul_full = (VW + 17)'(mul_mag) * (VW + 17)'(mul_c);
    mul_sh   = mul_full[VW+15:16];
    mul_res  = mul_v[VW-1] ? -$signed(mul_sh) : $signed(mul_sh);
  end

  // gain from octaves in q8.8
  logic [VW-10:0] e_oct;
  logic [16:0]    gain_nxt;
  assign e_oct    = prod_r[VW-2:8];
  assign gain_nxt = (e_oct >= (VW - 9)'(17)) ? 17'd0
                  : (cfd_pkg::EXPT[prod_r[7:3]] >> e_oct);

  function automatic logic signed [SB-1:0] sat_s(input logic signed [VW:0] v);
    logic signed [VW:0] hi, lo;
    hi = (VW + 1)'((2 ** (SB - 1)) - 1);
    lo = -hi - 1;
    if (v > hi)      return SB'(hi);
    else if (v < lo) return SB'(lo);
    else             return SB'(v);
  endfunction

  // echo addressing
  logic          ch_ok;
  logic [CW-1:0] ch_idx;
  logic [AW-1:0] wi, wi_inc, ri;
  logic [LW-1:0] len;
  logic [AW+1:0] rsum;
  logic [DAW-1:0] base;
  logic signed [SB-1:0] wr_val;

  assign ch_ok  = (CHANNELS > 1) || (ch_r == 1'b0);
  assign ch_idx = ch_ok ? CW'(ch_r) : '0;
  assign wi     = wi_r[ch_idx];
  assign wi_inc = (wi == AW'(MAX_DELAY - 1)) ? '0 : wi + 1'b1;
  assign len    = (LW'(cfg.delay_length) > LW'(MAX_DELAY)) ? LW'(MAX_DELAY)
                : LW'(cfg.delay_length);
  assign rsum   = (AW + 2)'(wi) + (AW + 2)'(MAX_DELAY) - (AW + 2)'(len);
  assign ri     = (rsum >= (AW + 2)'(MAX_DELAY)) ? AW'(rsum - (AW + 2)'(MAX_DELAY))
                : AW'(rsum);
  assign base   = DAW'(ch_idx) * DAW'(MAX_DELAY);
  assign wr_val = sat_s((VW + 1)'(d_r) + (VW + 1)'(prod_r));

  assign ram_re    = cmd.mem_rd;
  assign ram_raddr = base + DAW'(ri);
  assign ram_we    = cmd.clr_step || cmd.mem_wr;
  assign ram_waddr = cmd.clr_step ? clr_cnt_r : base + DAW'(wi);
  assign ram_wdata = cmd.clr_step ? '0 : wr_val;

  assign sts.fx_on    = cfg.fx_enable;
  assign sts.comp_on  = (cfg.comp_slope != 16'd0) && (over > 20'sd0);
  assign sts.echo_on  = (cfg.delay_length != 16'd0) && (cfg.delay_mix != 17'd0) && ch_ok;
  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.clr_last = (clr_cnt_r == DAW'(DEPTH - 1));

  assign out_valid   = out_valid_r;
  assign sample_out  = out_sample_r;
  assign channel_out = out_ch_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r  <= sample_in;
      ch_r <= channel;
      m_r  <= sample_in[SB-1] ? SB'(-sample_in) : SB'(sample_in);
    end
    if (cmd.load_level) begin
      d_r    <= x_r;
      over_r <= over[15:0];
    end
    if (cmd.load_gain) gain_r <= gain_nxt;
    if (cmd.mul_op == cfd_pkg::MUL_FBK) z_r <= $signed(ram_rdata);
    unique case (cmd.mul_op)
      cfd_pkg::MUL_ATT, cfd_pkg::MUL_EXP, cfd_pkg::MUL_FBK, cfd_pkg::MUL_DRY:
        prod_r <= mul_res;
      cfd_pkg::MUL_SCALE: d_r <= SB'(mul_res);
      cfd_pkg::MUL_WET:   d_r <= sat_s((VW + 1)'(prod_r) + (VW + 1)'(mul_res));
      default: ;
    endcase
    if (cmd.load_out) begin
      out_sample_r <= d_r;
      out_ch_r     <= ch_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      clr_cnt_r   <= '0;
      for (int c = 0; c < CHANNELS; c++) wi_r[c] <= '0;
    end else begin
      if (cmd.load_out)               out_valid_r <= 1'b1;
      else if (out_ready)             out_valid_r <= 1'b0;
      if (cmd.clr_step)               clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.mem_wr)                 wi_r[ch_idx] <= wi_inc;
    end
  end
endmodule

@@ rtl/compressor_feedback_delay_chain.sv @@
// Hard-knee compressor followed by a per-channel feedback echo, one sample in and one out.
// After reset the echo store (CHANNELS*MAX_DELAY words) is cleared one word per cycle,
// and no sample is taken until that is done. A sample then goes from transfer in to the
// output register through the level state alone when effects are off or neither stage
// applies; compression adds the attenuation, exponent, gain and scale states, echo adds
// read, feedback, write and wet, and both run in that order. The sequencer runs every
// multiply through one shared q0.16 multiplier and the echo ram's single read and write
// ports. The output register lets the next sample enter while a result still waits.
module compressor_feedback_delay_chain #(
  parameter int MAX_DELAY   = cfd_pkg::MAX_DELAY_DEF,
  parameter int CHANNELS    = cfd_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = cfd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  cfd_in_if.sink                     in_ch,
  cfd_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cfd_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  localparam int DEPTH = CHANNELS * MAX_DELAY;
  localparam int DAW   = $clog2(DEPTH);

  cfd_pkg::cfg_t cfg;
  cfd_pkg::cmd_t cmd;
  cfd_pkg::sts_t sts;

  logic                   ram_we, ram_re;
  logic [DAW-1:0]         ram_waddr, ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;

  cfd_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  cfd_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts, .cmd
  );

  cfd_dp #(
    .MAX_DELAY(MAX_DELAY), .CHANNELS(CHANNELS), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk, .rst_n, .cfg, .cmd, .sts,
    .sample_in   (in_ch.sample_in),
    .channel     (in_ch.channel),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .sample_out  (out_ch.sample_out),
    .channel_out (out_ch.channel_out),
    .ram_we, .ram_waddr, .ram_wdata, .ram_re, .ram_raddr, .ram_rdata
  );

  cfd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_echo_ram (
    .clk,
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );
endmodule

@@ rtl/cfd_checker.sv @@
// port-level checks for the compressor and echo block, bound to the top level
// depends on compressor_feedback_delay_chain_defines.svh
`include "compressor_feedback_delay_chain_defines.svh"

module cfd_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_sample,
  input logic                   pready
);
  // samples taken but not yet handed on
  logic [1:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'((in_valid && in_ready) ? 1 : 0)
                       - 2'((out_valid && out_ready) ? 1 : 0);
    end
  end

  `CFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sample))
  `CFD_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `CFD_ASSERT_NOW(a_no_phantom, out_valid, pend_r != 2'd0)
  `CFD_ASSERT_NOW(a_pready_high, 1'b1, pready)
endmodule

bind compressor_feedback_delay_chain cfd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_cfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.sample_out),
  .pready     (pready)
);
